>>> sv/lob_pkg.sv
`default_nettype none
package lob_pkg;

  localparam int ORDER_SLOTS_DEF = 1024;
  localparam int PRICE_TICKS_DEF = 256;
  localparam int QTY_BITS_DEF    = 24;
  localparam int MAX_RESULTS     = 64;
  localparam int FILL_BITS       = 7;
  localparam int FILLS_RESET     = 64;

  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_CANCEL,
    KIND_MODIFY,
    KIND_MATCH
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_DUP_ID,
    ST_UNKNOWN_ID,
    ST_SIDE_MISMATCH
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_RD_ID,
    OP_INS_WR,
    OP_MOD_WR,
    OP_AP_NEW,
    OP_AP_RD,
    OP_AP_LINK,
    OP_RM_RD_ID,
    OP_RM_RD_BID,
    OP_RM_RD_ASK,
    OP_RM_WR,
    OP_M_GRP,
    OP_M_BIT,
    OP_M_HEAD,
    OP_M_INFO,
    OP_M_FILL,
    OP_M_FILL2
  } dp_op_t;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_STATUS,
    EM_NOFILL,
    EM_FILL
  } emit_t;

  typedef struct packed {
    dp_op_t  op;
    logic    kill;
    emit_t   emit;
    status_t st;
    logic    last;
  } dp_cmd_t;

  typedef struct packed {
    logic  clr_last;
    kind_t kind;
    logic  live;
    logic  side_eq;
    logic  price_eq;
    logic  ap_busy;
    logic  go;
    logic  pend;
    logic  bid_empty;
    logic  ask_empty;
    logic  out_free;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DECIDE,
    S_RM_WR,
    S_MOD_WR,
    S_AP_CHK,
    S_AP_LINK,
    S_EMIT,
    S_M_GRP,
    S_M_BIT,
    S_M_CHK,
    S_M_INFO,
    S_M_FILL,
    S_M_FILL2,
    S_MB_RD,
    S_MB_WR,
    S_MA_RD,
    S_MA_WR
  } state_t;

endpackage
`default_nettype wire

>>> sv/lob_req_if.sv
`default_nettype none
interface lob_req_if #(
  parameter int IW = $clog2(lob_pkg::ORDER_SLOTS_DEF),
  parameter int TW = $clog2(lob_pkg::PRICE_TICKS_DEF),
  parameter int QW = lob_pkg::QTY_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic [1:0]    kind;
  logic [IW-1:0] order_id;
  logic          side;
  logic [TW-1:0] price_tick;
  logic [QW-1:0] quantity;

  modport source (output valid, kind, order_id, side, price_tick, quantity, input ready);
  modport sink (input valid, kind, order_id, side, price_tick, quantity, output ready);
endinterface
`default_nettype wire

>>> sv/lob_res_if.sv
`default_nettype none
interface lob_res_if #(
  parameter int IW = $clog2(lob_pkg::ORDER_SLOTS_DEF),
  parameter int TW = $clog2(lob_pkg::PRICE_TICKS_DEF),
  parameter int QW = lob_pkg::QTY_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic          is_trade;
  logic [IW-1:0] bid_id;
  logic [IW-1:0] ask_id;
  logic [TW-1:0] trade_price;
  logic [QW-1:0] trade_quantity;
  logic          still_crossed;
  logic          last;

  modport source (output valid, status, is_trade, bid_id, ask_id, trade_price,
                  trade_quantity, still_crossed, last, input ready);
  modport sink (input valid, status, is_trade, bid_id, ask_id, trade_price,
                trade_quantity, still_crossed, last, output ready);
endinterface
`default_nettype wire

>>> sv/lob_dp.sv
`default_nettype none
module lob_dp #(
  parameter int ORDER_SLOTS = 1024,
  parameter int PRICE_TICKS = 256,
  parameter int QTY_BITS    = 24
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  lob_pkg::dp_cmd_t                  cmd,
  output lob_pkg::dp_stat_t                 stat,
  input  wire                               cfg_we,
  input  wire [lob_pkg::FILL_BITS-1:0]      cfg_wdata,
  input  wire [1:0]                         in_kind,
  input  wire [$clog2(ORDER_SLOTS)-1:0]     in_order_id,
  input  wire                               in_side,
  input  wire [$clog2(PRICE_TICKS)-1:0]     in_price_tick,
  input  wire [QTY_BITS-1:0]                in_quantity,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [1:0]                        out_status,
  output logic                              out_is_trade,
  output logic [$clog2(ORDER_SLOTS)-1:0]    out_bid_id,
  output logic [$clog2(ORDER_SLOTS)-1:0]    out_ask_id,
  output logic [$clog2(PRICE_TICKS)-1:0]    out_trade_price,
  output logic [QTY_BITS-1:0]               out_trade_quantity,
  output logic                              out_still_crossed,
  output logic                              out_last
);
  import lob_pkg::*;

  localparam int IW  = $clog2(ORDER_SLOTS);
  localparam int TW  = $clog2(PRICE_TICKS);
  localparam int QW  = QTY_BITS;
  localparam int RW  = 1 + TW + QW;
  localparam int GW  = 16;
  localparam int GWB = $clog2(GW);
  localparam int NG  = (PRICE_TICKS + GW - 1) / GW;
  localparam int GB  = (NG > 1) ? $clog2(NG) : 1;
  localparam int FB  = FILL_BITS;

  // memories
  logic          live_mem [ORDER_SLOTS];
  logic [RW-1:0] info_mem [ORDER_SLOTS];
  logic [IW-1:0] next_mem [ORDER_SLOTS];
  logic [IW-1:0] prev_mem [ORDER_SLOTS];
  logic [IW-1:0] bh_mem [PRICE_TICKS];
  logic [IW-1:0] bt_mem [PRICE_TICKS];
  logic [IW-1:0] ah_mem [PRICE_TICKS];
  logic [IW-1:0] at_mem [PRICE_TICKS];

  logic          live_q_r;
  logic [RW-1:0] info_a_q_r, info_b_q_r;
  logic [IW-1:0] next_q_r, prev_q_r;
  logic [IW-1:0] bh_q_r, bt_q_r, ah_q_r, at_q_r;

  // control registers
  logic [IW-1:0]          clr_r;
  logic [FB-1:0]          n_r;
  logic                   pend_r;
  logic                   out_v_r;
  logic [FB-1:0]          max_fills_r;
  logic [PRICE_TICKS-1:0] bid_busy_r, ask_busy_r;

  // working registers
  kind_t         kind_r;
  logic [IW-1:0] id_r;
  logic          side_r;
  logic [TW-1:0] price_r;
  logic [QW-1:0] qty_r;
  logic [IW-1:0] ap_id_r, rm_id_r, bi_r, ai_r, pb_r, pa_r;
  logic          ap_s_r, rm_s_r;
  logic [TW-1:0] ap_p_r, rm_p_r, b_r, a_r, px_r;
  logic [GB-1:0] bg_r, ag_r;
  logic          hb_r, ha_r;
  logic [QW-1:0] pf_r, aq_rem_r;
  logic          bz_r, az_r;

  logic [1:0]    out_status_r;
  logic          out_is_trade_r, out_sc_r, out_last_r;
  logic [IW-1:0] out_bid_r, out_ask_r;
  logic [TW-1:0] out_px_r;
  logic [QW-1:0] out_qty_r;

  // combinational
  logic [IW:0]          id_ext;
  logic [IW-1:0]        id_in;
  logic [TW:0]          tick_ext;
  logic [TW-1:0]        tick_in;
  logic                 a_side;
  logic [TW-1:0]        a_price;
  logic [QW-1:0]        a_qty, b_qty, fill;
  logic [FB-1:0]        lim;
  logic                 crossed, more, out_free;
  logic [NG*GW-1:0]     bid_pad, ask_pad;
  logic [NG-1:0]        bgrp, agrp;
  logic [GB-1:0]        bg_nxt, ag_nxt;
  logic                 hb_nxt, ha_nxt;
  logic [GW-1:0]        bw, aw;
  logic [GWB-1:0]       bbit, abit;
  logic [TW-1:0]        lvl_addr, bh_ra, ah_ra;
  logic [IW-1:0]        link_ra, info_ra;
  logic [IW-1:0]        rm_h, rm_t, ap_tail;
  logic                 busy_set, busy_clr;
  logic                 head_we, tail_we;
  logic [IW-1:0]        head_wd, tail_wd;
  logic                 next_we, prev_we;
  logic [IW-1:0]        next_wa, next_wd, prev_wa, prev_wd;
  logic                 info_we;
  logic [IW-1:0]        info_wa;
  logic [RW-1:0]        info_wd;
  logic                 live_we, live_wd;
  logic [IW-1:0]        live_wa;

  assign id_ext   = {1'b0, in_order_id};
  assign id_in    = (id_ext >= (IW+1)'(ORDER_SLOTS)) ?
                    IW'(id_ext - (IW+1)'(ORDER_SLOTS)) : in_order_id;
  assign tick_ext = {1'b0, in_price_tick};
  assign tick_in  = (tick_ext >= (TW+1)'(PRICE_TICKS)) ?
                    TW'(tick_ext - (TW+1)'(PRICE_TICKS)) : in_price_tick;

  assign a_side  = info_a_q_r[RW-1];
  assign a_price = info_a_q_r[QW +: TW];
  assign a_qty   = info_a_q_r[QW-1:0];
  assign b_qty   = info_b_q_r[QW-1:0];
  assign fill    = (a_qty < b_qty) ? a_qty : b_qty;

  assign lim      = (max_fills_r == '0) ? FB'(1) :
                    (max_fills_r > FB'(MAX_RESULTS)) ? FB'(MAX_RESULTS) : max_fills_r;
  assign crossed  = hb_r && ha_r && (b_r >= a_r);
  assign more     = n_r < lim;
  assign out_free = !out_v_r || out_ready;

  // best level search: group summary first, then bit within group
  assign bid_pad = (NG*GW)'(bid_busy_r);
  assign ask_pad = (NG*GW)'(ask_busy_r);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      bgrp[g] = |bid_pad[g*GW +: GW];
      agrp[g] = |ask_pad[g*GW +: GW];
    end
    bg_nxt = '0;
    hb_nxt = 1'b0;
    for (int g = 0; g < NG; g++) begin
      if (bgrp[g]) begin
        bg_nxt = g[GB-1:0];
        hb_nxt = 1'b1;
      end
    end
    ag_nxt = '0;
    ha_nxt = 1'b0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (agrp[g]) begin
        ag_nxt = g[GB-1:0];
        ha_nxt = 1'b1;
      end
    end
    bw = '0;
    aw = '0;
    for (int g = 0; g < NG; g++) begin
      if (bg_r == g[GB-1:0]) bw = bid_pad[g*GW +: GW];
      if (ag_r == g[GB-1:0]) aw = ask_pad[g*GW +: GW];
    end
    bbit = '0;
    for (int j = 0; j < GW; j++) begin
      if (bw[j]) bbit = j[GWB-1:0];
    end
    abit = '0;
    for (int j = GW - 1; j >= 0; j--) begin
      if (aw[j]) abit = j[GWB-1:0];
    end
  end

  // read addresses
  always_comb begin
    case (cmd.op)
      OP_RM_RD_ID:  lvl_addr = a_price;
      OP_RM_RD_BID: lvl_addr = b_r;
      OP_RM_RD_ASK: lvl_addr = a_r;
      default:      lvl_addr = ap_p_r;
    endcase
    case (cmd.op)
      OP_RM_RD_BID: link_ra = bi_r;
      OP_RM_RD_ASK: link_ra = ai_r;
      default:      link_ra = id_r;
    endcase
    bh_ra   = (cmd.op == OP_M_HEAD) ? b_r : lvl_addr;
    ah_ra   = (cmd.op == OP_M_HEAD) ? a_r : lvl_addr;
    info_ra = (cmd.op == OP_M_INFO) ? bh_q_r : id_r;
  end

  assign rm_h    = rm_s_r ? ah_q_r : bh_q_r;
  assign rm_t    = rm_s_r ? at_q_r : bt_q_r;
  assign ap_tail = ap_s_r ? at_q_r : bt_q_r;

  // write ports
  always_comb begin
    busy_set = 1'b0;
    busy_clr = 1'b0;
    head_we  = 1'b0;
    head_wd  = ap_id_r;
    tail_we  = 1'b0;
    tail_wd  = ap_id_r;
    next_we  = 1'b0;
    next_wa  = ap_tail;
    next_wd  = ap_id_r;
    prev_we  = 1'b0;
    prev_wa  = ap_id_r;
    prev_wd  = ap_tail;
    info_we  = 1'b0;
    info_wa  = id_r;
    info_wd  = {side_r, price_r, qty_r};
    live_we  = 1'b0;
    live_wa  = id_r;
    live_wd  = 1'b0;
    case (cmd.op)
      OP_CLEAR: begin
        live_we = 1'b1;
        live_wa = clr_r;
      end
      OP_INS_WR: begin
        info_we = 1'b1;
        live_we = 1'b1;
        live_wd = 1'b1;
      end
      OP_MOD_WR: begin
        info_we = 1'b1;
      end
      OP_AP_NEW: begin
        busy_set = 1'b1;
        head_we  = 1'b1;
        tail_we  = 1'b1;
      end
      OP_AP_LINK: begin
        tail_we = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      OP_RM_WR: begin
        live_we = cmd.kill;
        live_wa = rm_id_r;
        next_wa = prev_q_r;
        next_wd = next_q_r;
        prev_wa = next_q_r;
        prev_wd = prev_q_r;
        head_wd = next_q_r;
        tail_wd = prev_q_r;
        if (rm_h == rm_t) begin
          busy_clr = 1'b1;
        end else if (rm_h == rm_id_r) begin
          head_we = 1'b1;
        end else if (rm_t == rm_id_r) begin
          tail_we = 1'b1;
        end else begin
          next_we = 1'b1;
          prev_we = 1'b1;
        end
      end
      OP_M_FILL: begin
        info_we = 1'b1;
        info_wa = bi_r;
        info_wd = {1'b0, b_r, a_qty - fill};
      end
      OP_M_FILL2: begin
        info_we = 1'b1;
        info_wa = ai_r;
        info_wd = {1'b1, a_r, aq_rem_r};
      end
      default: begin
      end
    endcase
  end

  // level side and address follow the operation
  logic          lvl_side;
  logic [TW-1:0] lvl_wa;
  assign lvl_side = (cmd.op == OP_RM_WR) ? rm_s_r : ap_s_r;
  assign lvl_wa   = (cmd.op == OP_RM_WR) ? rm_p_r : ap_p_r;

  always_ff @(posedge clk) begin
    if (live_we) live_mem[live_wa] <= live_wd;
    live_q_r <= live_mem[id_r];
    if (info_we) info_mem[info_wa] <= info_wd;
    info_a_q_r <= info_mem[info_ra];
    info_b_q_r <= info_mem[ah_q_r];
    if (next_we) next_mem[next_wa] <= next_wd;
    next_q_r <= next_mem[link_ra];
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_q_r <= prev_mem[link_ra];
    if (head_we && !lvl_side) bh_mem[lvl_wa] <= head_wd;
    bh_q_r <= bh_mem[bh_ra];
    if (head_we && lvl_side) ah_mem[lvl_wa] <= head_wd;
    ah_q_r <= ah_mem[ah_ra];
    if (tail_we && !lvl_side) bt_mem[lvl_wa] <= tail_wd;
    bt_q_r <= bt_mem[lvl_addr];
    if (tail_we && lvl_side) at_mem[lvl_wa] <= tail_wd;
    at_q_r <= at_mem[lvl_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      n_r         <= '0;
      pend_r      <= 1'b0;
      out_v_r     <= 1'b0;
      max_fills_r <= FB'(FILLS_RESET);
      bid_busy_r  <= '0;
      ask_busy_r  <= '0;
    end else begin
      if (cfg_we) max_fills_r <= cfg_wdata;
      if (cmd.op == OP_CLEAR) clr_r <= clr_r + 1'b1;
      if (cmd.op == OP_LOAD) begin
        n_r    <= '0;
        pend_r <= 1'b0;
      end
      if (cmd.op == OP_M_FILL) begin
        n_r    <= n_r + 1'b1;
        pend_r <= 1'b1;
      end
      if (cmd.emit == EM_FILL) pend_r <= 1'b0;
      if (cmd.emit != EM_NONE) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (busy_set) begin
        if (ap_s_r) ask_busy_r[ap_p_r] <= 1'b1;
        else bid_busy_r[ap_p_r] <= 1'b1;
      end
      if (busy_clr) begin
        if (rm_s_r) ask_busy_r[rm_p_r] <= 1'b0;
        else bid_busy_r[rm_p_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_r  <= kind_t'(in_kind);
        id_r    <= id_in;
        side_r  <= in_side;
        price_r <= tick_in;
        qty_r   <= in_quantity;
      end
      OP_INS_WR, OP_MOD_WR: begin
        ap_id_r <= id_r;
        ap_s_r  <= side_r;
        ap_p_r  <= price_r;
      end
      OP_RM_RD_ID: begin
        rm_id_r <= id_r;
        rm_s_r  <= a_side;
        rm_p_r  <= lvl_addr;
      end
      OP_RM_RD_BID: begin
        rm_id_r <= bi_r;
        rm_s_r  <= 1'b0;
        rm_p_r  <= lvl_addr;
      end
      OP_RM_RD_ASK: begin
        rm_id_r <= ai_r;
        rm_s_r  <= 1'b1;
        rm_p_r  <= lvl_addr;
      end
      OP_M_GRP: begin
        bg_r <= bg_nxt;
        ag_r <= ag_nxt;
        hb_r <= hb_nxt;
        ha_r <= ha_nxt;
      end
      OP_M_BIT: begin
        b_r <= TW'({bg_r, bbit});
        a_r <= TW'({ag_r, abit});
      end
      OP_M_INFO: begin
        bi_r <= bh_q_r;
        ai_r <= ah_q_r;
      end
      OP_M_FILL: begin
        pb_r     <= bi_r;
        pa_r     <= ai_r;
        px_r     <= a_r;
        pf_r     <= fill;
        aq_rem_r <= b_qty - fill;
        bz_r     <= (a_qty == fill);
        az_r     <= (b_qty == fill);
      end
      default: begin
      end
    endcase
    case (cmd.emit)
      EM_STATUS, EM_NOFILL: begin
        out_status_r   <= (cmd.emit == EM_STATUS) ? cmd.st : ST_OK;
        out_is_trade_r <= 1'b0;
        out_bid_r      <= '0;
        out_ask_r      <= '0;
        out_px_r       <= '0;
        out_qty_r      <= '0;
        out_sc_r       <= 1'b0;
        out_last_r     <= 1'b1;
      end
      EM_FILL: begin
        out_status_r   <= ST_OK;
        out_is_trade_r <= 1'b1;
        out_bid_r      <= pb_r;
        out_ask_r      <= pa_r;
        out_px_r       <= px_r;
        out_qty_r      <= pf_r;
        out_sc_r       <= cmd.last && crossed;
        out_last_r     <= cmd.last;
      end
      default: begin
      end
    endcase
  end

  assign stat.clr_last  = (clr_r == IW'(ORDER_SLOTS - 1));
  assign stat.kind      = kind_r;
  assign stat.live      = live_q_r;
  assign stat.side_eq   = (a_side == side_r);
  assign stat.price_eq  = (a_price == price_r);
  assign stat.ap_busy   = ap_s_r ? ask_busy_r[ap_p_r] : bid_busy_r[ap_p_r];
  assign stat.go        = crossed && more;
  assign stat.pend      = pend_r;
  assign stat.bid_empty = bz_r;
  assign stat.ask_empty = az_r;
  assign stat.out_free  = out_free;

  assign out_valid          = out_v_r;
  assign out_status         = out_status_r;
  assign out_is_trade       = out_is_trade_r;
  assign out_bid_id         = out_bid_r;
  assign out_ask_id         = out_ask_r;
  assign out_trade_price    = out_px_r;
  assign out_trade_quantity = out_qty_r;
  assign out_still_crossed  = out_sc_r;
  assign out_last           = out_last_r;

  a_nofill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_is_trade_r |-> out_bid_r == '0 && out_qty_r == '0 && !out_sc_r)
    else $error("non-fill result carries fill data");
  a_crossed_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_sc_r |-> out_last_r && out_is_trade_r)
    else $error("still crossed flag away from final fill");
  a_fill_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_is_trade_r |-> out_status_r == ST_OK)
    else $error("fill with error status");
  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_M_FILL |-> n_r < lim)
    else $error("fill beyond limit");

endmodule
`default_nettype wire

>>> sv/lob_ctrl.sv
`default_nettype none
module lob_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  lob_pkg::dp_stat_t stat,
  output lob_pkg::dp_cmd_t  cmd
);
  import lob_pkg::*;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.kill  = 1'b0;
    cmd.emit  = EM_NONE;
    cmd.st    = st_r;
    cmd.last  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.op    = OP_RD_ID;
        st_nxt    = ST_OK;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        case (stat.kind)
          KIND_INSERT: begin
            if (stat.live) begin
              st_nxt    = ST_DUP_ID;
              state_nxt = S_EMIT;
            end else begin
              cmd.op    = OP_INS_WR;
              state_nxt = S_AP_CHK;
            end
          end
          KIND_CANCEL: begin
            if (!stat.live) begin
              st_nxt    = ST_UNKNOWN_ID;
              state_nxt = S_EMIT;
            end else begin
              cmd.op    = OP_RM_RD_ID;
              state_nxt = S_RM_WR;
            end
          end
          KIND_MODIFY: begin
            if (!stat.live) begin
              st_nxt    = ST_UNKNOWN_ID;
              state_nxt = S_EMIT;
            end else if (!stat.side_eq) begin
              st_nxt    = ST_SIDE_MISMATCH;
              state_nxt = S_EMIT;
            end else if (!stat.price_eq) begin
              cmd.op    = OP_RM_RD_ID;
              state_nxt = S_RM_WR;
            end else begin
              cmd.op    = OP_MOD_WR;
              state_nxt = S_EMIT;
            end
          end
          default: begin
            state_nxt = S_M_GRP;
          end
        endcase
      end
      S_RM_WR: begin
        cmd.op    = OP_RM_WR;
        cmd.kill  = (stat.kind == KIND_CANCEL);
        state_nxt = (stat.kind == KIND_CANCEL) ? S_EMIT : S_MOD_WR;
      end
      S_MOD_WR: begin
        cmd.op    = OP_MOD_WR;
        state_nxt = S_AP_CHK;
      end
      S_AP_CHK: begin
        if (stat.ap_busy) begin
          cmd.op    = OP_AP_RD;
          state_nxt = S_AP_LINK;
        end else begin
          cmd.op    = OP_AP_NEW;
          state_nxt = S_EMIT;
        end
      end
      S_AP_LINK: begin
        cmd.op    = OP_AP_LINK;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = EM_STATUS;
          state_nxt = S_IDLE;
        end
      end
      S_M_GRP: begin
        cmd.op    = OP_M_GRP;
        state_nxt = S_M_BIT;
      end
      S_M_BIT: begin
        cmd.op    = OP_M_BIT;
        state_nxt = S_M_CHK;
      end
      S_M_CHK: begin
        if (stat.pend) begin
          if (stat.out_free) begin
            cmd.emit = EM_FILL;
            cmd.last = !stat.go;
            if (stat.go) begin
              cmd.op    = OP_M_HEAD;
              state_nxt = S_M_INFO;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end else if (stat.go) begin
          cmd.op    = OP_M_HEAD;
          state_nxt = S_M_INFO;
        end else if (stat.out_free) begin
          cmd.emit  = EM_NOFILL;
          state_nxt = S_IDLE;
        end
      end
      S_M_INFO: begin
        cmd.op    = OP_M_INFO;
        state_nxt = S_M_FILL;
      end
      S_M_FILL: begin
        cmd.op    = OP_M_FILL;
        state_nxt = S_M_FILL2;
      end
      S_M_FILL2: begin
        cmd.op = OP_M_FILL2;
        if (stat.bid_empty) state_nxt = S_MB_RD;
        else if (stat.ask_empty) state_nxt = S_MA_RD;
        else state_nxt = S_M_GRP;
      end
      S_MB_RD: begin
        cmd.op    = OP_RM_RD_BID;
        state_nxt = S_MB_WR;
      end
      S_MB_WR: begin
        cmd.op    = OP_RM_WR;
        cmd.kill  = 1'b1;
        state_nxt = stat.ask_empty ? S_MA_RD : S_M_GRP;
      end
      S_MA_RD: begin
        cmd.op    = OP_RM_RD_ASK;
        state_nxt = S_MA_WR;
      end
      S_MA_WR: begin
        cmd.op    = OP_RM_WR;
        cmd.kill  = 1'b1;
        state_nxt = S_M_GRP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && in_valid |=> state_r == S_READ)
    else $error("request accepted outside idle");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit != EM_NONE |-> stat.out_free)
    else $error("result pushed into full output register");
  a_match_route: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_M_CHK && !stat.pend && !stat.go && stat.out_free |-> cmd.emit == EM_NOFILL)
    else $error("empty match gives no result");

endmodule
`default_nettype wire

>>> sv/limit_order_book_matcher.sv
`default_nettype none
// single-instrument limit order book with price-time priority matching. after reset the
// order-valid store is cleared slot by slot, during which no request is taken. insert,
// cancel and modify each give one status result; a match request repeats the best-level
// search (group summary, then bit) and for each fill reads the order and level memories
// through registered reads, and gives one result per fill (at most max_fills, taken as 1
// when zero and capped at MAX_RESULTS) or one empty result when the book is not crossed.
module limit_order_book_matcher #(
  parameter int ORDER_SLOTS = lob_pkg::ORDER_SLOTS_DEF,
  parameter int PRICE_TICKS = lob_pkg::PRICE_TICKS_DEF,
  parameter int QTY_BITS    = lob_pkg::QTY_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  lob_req_if.sink                      in_req,
  lob_res_if.source                    out_res,
  input  wire                          cfg_we,
  input  wire [lob_pkg::FILL_BITS-1:0] cfg_wdata
);
  import lob_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     ready;

  assign in_req.ready = ready;

  lob_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lob_dp #(
    .ORDER_SLOTS (ORDER_SLOTS),
    .PRICE_TICKS (PRICE_TICKS),
    .QTY_BITS    (QTY_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_kind            (in_req.kind),
    .in_order_id        (in_req.order_id),
    .in_side            (in_req.side),
    .in_price_tick      (in_req.price_tick),
    .in_quantity        (in_req.quantity),
    .out_valid          (out_res.valid),
    .out_ready          (out_res.ready),
    .out_status         (out_res.status),
    .out_is_trade       (out_res.is_trade),
    .out_bid_id         (out_res.bid_id),
    .out_ask_id         (out_res.ask_id),
    .out_trade_price    (out_res.trade_price),
    .out_trade_quantity (out_res.trade_quantity),
    .out_still_crossed  (out_res.still_crossed),
    .out_last           (out_res.last)
  );

endmodule
`default_nettype wire
